// ===== src/assert_macros.svh =====
// assertion macros included by the step core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/dcms_pkg.sv =====
// types shared by the microengine step core and its execute unit
package dcms_pkg;

   // one decoded microword plus channel signals; declared from the top bit down so
   // that a_source sits in the lowest bits of the packed word
   typedef struct packed {
      logic [13:0] channel_in;
      logic        bypass;
      logic [7:0]  constant;
      logic [7:0]  next_low;
      logic [3:0]  status_op;
      logic [3:0]  low_branch;
      logic [3:0]  high_branch;
      logic [4:0]  dest_select;
      logic        invert_b;
      logic [2:0]  alu_function;
      logic [1:0]  b_source;
      logic [4:0]  a_source;
   } req_type;

   // one result, next_address in the lowest bits
   typedef struct packed {
      logic        data_written;
      logic [7:0]  fc_out;
      logic [7:0]  ft_out;
      logic [7:0]  tag_gate_out;
      logic [7:0]  data_word_out;
      logic [7:0]  op_reg_out;
      logic [7:0]  status_reg;
      logic        nonzero_flag;
      logic        carry_flag;
      logic [7:0]  a_bus;
      logic [7:0]  alu_result;
      logic [11:0] next_address;
   } rsp_type;

   // architectural state of the microengine; registers that are never written
   // (WH, WL, BC, BX, ER, CX) always read as zero and hold no storage
   typedef struct packed {
      logic [11:0] micro_address;
      logic [7:0]  gl;
      logic [7:0]  by;
      logic [7:0]  fr;
      logic [7:0]  kl;
      logic [7:0]  dl;
      logic [7:0]  dh;
      logic [7:0]  op;
      logic [7:0]  gp;
      logic [7:0]  sp;
      logic [7:0]  dw;
      logic [7:0]  dr;
      logic [7:0]  ie;
      logic [7:0]  ur;
      logic [7:0]  ft;
      logic [7:0]  fc;
      logic [7:0]  ig;
      logic [7:0]  status;
      logic [7:0]  last_a;
      logic        carry;
      logic        nonzero;
   } state_type;

   localparam int REQ_BYTES_W = 64;
   localparam int RSP_BYTES_W = 80;

   // configuration register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;

endpackage

// ===== src/disk_ctrl_micro_step_core.sv =====
// top level of the disk controller microengine step core
// path: an accepted request is held in the input register, then its result in the output register
// throughput: one microword per cycle while rsp_tready holds; the execute stage reads the state
//   written by the previous microword, so the address and flag update loop closes between microwords
// reset: synchronous, active high; clears the microaddress, byte registers, status,
//   flags, last a bus value, device address and both stage valid bits
module disk_ctrl_micro_step_core (
   input  logic        clock,
   input  logic        reset,
   // request: a_source, b_source, alu_function, invert_b, dest_select, high_branch,
   //   low_branch, status_op, next_low, constant, bypass, channel_in, zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [dcms_pkg::REQ_BYTES_W-1:0] req_tdata,
   // response: next_address, alu_result, a_bus, carry_flag, nonzero_flag, status_reg,
   //   op_reg_out, data_word_out, tag_gate_out, ft_out, fc_out, data_written, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [dcms_pkg::RSP_BYTES_W-1:0] rsp_tdata,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dcms_pkg::*;
   `include "assert_macros.svh"

   localparam int REQ_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);

   // input stage
   req_type   item_ff, item_in;
   logic      item_valid_ff, item_valid_in;
   // output stage
   rsp_type   rsp_ff;
   rsp_type   rsp_calc;
   logic      rsp_valid_ff, rsp_valid_in;
   // architectural state
   state_type state_ff;
   state_type state_calc;
   logic [7:0] dev_addr_ff, dev_addr_in;

   logic req_take;
   logic exec_fire;
   logic csr_wr;
   logic csr_index;

   // execute when the output register is empty or being emptied this cycle
   assign exec_fire  = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   // the input register refills as it drains, so a transaction every cycle unless the response is stalled
   assign req_tready = !item_valid_ff || exec_fire;
   assign req_take   = req_tvalid && req_tready;

   assign item_in       = req_take ? req_type'(req_tdata[REQ_W-1:0]) : item_ff;
   assign item_valid_in = req_take ? 1'b1 : (exec_fire ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = exec_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   dcms_exec u_exec (
      .item           (item_ff),
      .cur            (state_ff),
      .device_address (dev_addr_ff),
      .nxt            (state_calc),
      .rsp            (rsp_calc)
   );

   // configuration port, one word register at index zero
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign dev_addr_in = (csr_wr && csr_index == CSR_DEVICE_ADDRESS) ? csr_pwdata[7:0]
                                                                     : dev_addr_ff;

   always_comb begin
      csr_prdata = 32'h0000_0000;
      if (csr_index == CSR_DEVICE_ADDRESS) begin
         csr_prdata = {24'h00_0000, dev_addr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
         dev_addr_ff   <= 8'h00;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         dev_addr_ff   <= dev_addr_in;
         if (exec_fire) begin
            state_ff <= state_calc;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (exec_fire) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BYTES_W-RSP_W){1'b0}}, rsp_ff};

   // a stalled request side means both stages are full and the response is held
   `ASSERT_SAME(a_stall_only_when_full, clock, reset, !req_tready,
                item_valid_ff && rsp_valid_ff && !rsp_tready)
   // the reported next address is the microaddress the core moved to
   `ASSERT_NEXT(a_addr_matches_state, clock, reset, exec_fire,
                rsp_ff.next_address == state_ff.micro_address)
   // the reported status is the status the core now holds
   `ASSERT_NEXT(a_status_matches_state, clock, reset, exec_fire,
                rsp_valid_ff && rsp_ff.status_reg == state_ff.status)

endmodule

// ===== src/dcms_exec.sv =====
// execute unit: next address, bus gating, alu and register update for one microword
module dcms_exec (
   input  dcms_pkg::req_type   item,
   input  dcms_pkg::state_type cur,
   input  logic [7:0]          device_address,
   output dcms_pkg::state_type nxt,
   output dcms_pkg::rsp_type   rsp
);
   import dcms_pkg::*;

   // high branch codes
   localparam logic [3:0] HB_NEVER = 4'd0,  HB_ONE = 4'd1,   HB_ST0 = 4'd2,  HB_OP6 = 4'd3;
   localparam logic [3:0] HB_ST2 = 4'd4,    HB_ST4 = 4'd5,   HB_ST6 = 4'd6,  HB_ONE7 = 4'd7;
   localparam logic [3:0] HB_PAGE = 4'd8,   HB_CARRY = 4'd9, HB_CMD = 4'd10, HB_SUP = 4'd11;
   localparam logic [3:0] HB_ONE12 = 4'd12, HB_OP0 = 4'd13,  HB_OP2 = 4'd14, HB_OP4 = 4'd15;
   // low branch codes
   localparam logic [3:0] LB_NEVER = 4'd0,  LB_ONE = 4'd1,   LB_ST3 = 4'd2,  LB_ST5 = 4'd3;
   localparam logic [3:0] LB_ST7 = 4'd4,    LB_ZERO = 4'd5,  LB_ABUS = 4'd6, LB_ONE7 = 4'd7;
   localparam logic [3:0] LB_SRV = 4'd8,    LB_TAG = 4'd9,   LB_SEL = 4'd10, LB_OP1 = 4'd11;
   localparam logic [3:0] LB_OP3 = 4'd12,   LB_OP5 = 4'd13,  LB_ONE14 = 4'd14, LB_OP7 = 4'd15;
   // b bus sources
   localparam logic [1:0] BS_ZERO = 2'd0, BS_BY = 2'd1, BS_CONST = 2'd2, BS_DR = 2'd3;
   // a bus sources
   localparam logic [4:0] AS_ZERO = 5'd0, AS_GL = 5'd1, AS_BY = 5'd2, AS_BUS = 5'd3;
   localparam logic [4:0] AS_FR = 5'd4, AS_KL = 5'd5, AS_DL = 5'd6, AS_DH = 5'd7;
   localparam logic [4:0] AS_OP = 5'd8, AS_GP = 5'd9, AS_SP = 5'd10, AS_DW = 5'd11;
   localparam logic [4:0] AS_WH = 5'd12, AS_WL = 5'd13, AS_BC = 5'd15, AS_Z16 = 5'd16;
   localparam logic [4:0] AS_Z17 = 5'd17, AS_Z18 = 5'd18, AS_BX = 5'd19, AS_DR = 5'd20;
   localparam logic [4:0] AS_ER = 5'd21, AS_IE = 5'd22, AS_Z23 = 5'd23, AS_CX = 5'd24;
   localparam logic [4:0] AS_IS = 5'd25, AS_UR = 5'd26, AS_UR2 = 5'd27;
   // alu functions
   localparam logic [2:0] AF_ADD = 3'd0, AF_ADD1 = 3'd1, AF_AND = 3'd2, AF_OR = 3'd3;
   localparam logic [2:0] AF_ADDS = 3'd4, AF_ADD1S = 3'd5, AF_ADDST3 = 3'd6, AF_XOR = 3'd7;
   // destinations
   localparam logic [4:0] DS_GL = 5'd1, DS_BY = 5'd2, DS_FR = 5'd4, DS_KL = 5'd5;
   localparam logic [4:0] DS_DL = 5'd6, DS_DH = 5'd7, DS_OP = 5'd8, DS_GP = 5'd9;
   localparam logic [4:0] DS_UR = 5'd10, DS_DW = 5'd11, DS_DR = 5'd12, DS_FT = 5'd13;
   localparam logic [4:0] DS_FC = 5'd14, DS_IG = 5'd15, DS_SP = 5'd26, DS_IE = 5'd28;
   // status operations
   localparam logic [3:0] SO_NOP = 4'd0, SO_CLR0 = 4'd1, SO_CLR0B = 4'd2, SO_CLR1 = 4'd3;
   localparam logic [3:0] SO_SET1 = 4'd4, SO_CLR2 = 4'd5, SO_CLR2NZ = 4'd6, SO_SET3 = 4'd7;
   localparam logic [3:0] SO_CLR3 = 4'd8, SO_SET4 = 4'd9, SO_CLR5 = 4'd10, SO_SET5 = 4'd11;
   localparam logic [3:0] SO_CLR6 = 4'd12, SO_SET6 = 4'd13, SO_CLR7 = 4'd14, SO_SET7 = 4'd15;

   logic [11:0] nx;
   logic        hi_cond;
   logic        lo_cond;
   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic [8:0]  sum;
   logic [7:0]  alu;
   logic        carry;
   logic [7:0]  res;
   logic [7:0]  st;
   logic        dw_wr;
   logic [7:0]  s;
   logic [7:0]  o;

   // ibm numbering: bit 0 is the msb
   assign s = cur.status;
   assign o = cur.op;

   // next address
   always_comb begin
      nx      = {cur.micro_address[11:8], item.next_low};
      hi_cond = 1'b0;
      lo_cond = 1'b0;
      unique case (item.high_branch)
         HB_NEVER:                  hi_cond = 1'b0;
         HB_ONE, HB_ONE7, HB_ONE12: hi_cond = 1'b1;
         HB_ST0:                    hi_cond = s[7];
         HB_OP6:                    hi_cond = o[1];
         HB_ST2:                    hi_cond = s[5];
         HB_ST4:                    hi_cond = s[3];
         HB_ST6:                    hi_cond = s[1];
         HB_PAGE:                   nx[11:8] = item.constant[3:0];
         HB_CARRY:                  hi_cond = cur.carry;
         HB_CMD:                    hi_cond = item.channel_in[8];
         HB_SUP:                    hi_cond = item.channel_in[9];
         HB_OP0:                    hi_cond = o[7];
         HB_OP2:                    hi_cond = o[5];
         HB_OP4:                    hi_cond = o[3];
         default:                   hi_cond = 1'b0;
      endcase
      if (hi_cond) begin
         nx[1] = 1'b1;
      end
      unique case (item.low_branch)
         LB_NEVER:                  lo_cond = 1'b0;
         LB_ONE, LB_ONE7, LB_ONE14: lo_cond = 1'b1;
         LB_ST3:                    lo_cond = s[4];
         LB_ST5:                    lo_cond = s[2];
         LB_ST7:                    lo_cond = s[0];
         LB_ZERO:                   lo_cond = !cur.nonzero;
         // replaces the whole low byte, including any bit set by the high branch
         LB_ABUS:                   nx[7:0] = cur.last_a;
         LB_SRV:                    lo_cond = item.channel_in[10];
         LB_TAG:                    lo_cond = !item.channel_in[12] && !item.channel_in[13]
                                              && cur.ig[5];
         LB_SEL:                    lo_cond = item.channel_in[11];
         LB_OP1:                    lo_cond = o[6];
         LB_OP3:                    lo_cond = o[4];
         LB_OP5:                    lo_cond = o[2];
         LB_OP7:                    lo_cond = o[0];
         default:                   lo_cond = 1'b0;
      endcase
      if (lo_cond) begin
         nx[0] = 1'b1;
      end
   end

   // bus gating
   always_comb begin
      unique case (item.b_source)
         BS_ZERO:  b = 8'h00;
         BS_BY:    b = cur.by;
         BS_CONST: b = item.constant;
         BS_DR:    b = cur.dr;
         default:  b = 8'h00;
      endcase
      if (item.invert_b) begin
         b = ~b;
      end
   end

   always_comb begin
      unique case (item.a_source)
         AS_ZERO, AS_Z16, AS_Z17, AS_Z18, AS_Z23: a = 8'h00;
         AS_GL:          a = cur.gl;
         AS_BY:          a = cur.by;
         AS_BUS:         a = item.channel_in[7:0];
         AS_FR:          a = cur.fr;
         AS_KL:          a = cur.kl;
         AS_DL:          a = cur.dl;
         AS_DH:          a = cur.dh;
         AS_OP:          a = cur.op;
         AS_GP:          a = cur.gp;
         AS_SP:          a = cur.sp;
         AS_DW:          a = cur.dw;
         // no destination code reaches these; they hold no storage and read as zero
         AS_WH, AS_WL, AS_BC, AS_BX, AS_ER, AS_CX: a = 8'h00;
         AS_DR:          a = cur.dr;
         AS_IE:          a = cur.ie;
         AS_IS:          a = device_address;
         AS_UR, AS_UR2:  a = cur.ur;
         // hold codes drive the previous value again
         default:        a = cur.last_a;
      endcase
   end

   // alu
   always_comb begin
      unique case (item.alu_function)
         AF_ADD1, AF_ADD1S: cin = 1'b1;
         AF_ADDST3:         cin = s[4];
         default:           cin = 1'b0;
      endcase
      sum   = {1'b0, a} + {1'b0, b} + {8'h00, cin};
      carry = 1'b0;
      unique case (item.alu_function)
         AF_AND:  alu = a & b;
         AF_OR:   alu = a | b;
         AF_XOR:  alu = a ^ b;
         default: begin
            alu   = sum[7:0];
            carry = sum[8];
         end
      endcase
      res = item.bypass ? a : alu;
   end

   // destination write and flags
   always_comb begin
      nxt               = cur;
      nxt.micro_address = nx;
      nxt.last_a        = a;
      nxt.carry         = carry;
      nxt.nonzero       = (alu != 8'h00);
      dw_wr             = 1'b0;
      unique case (item.dest_select)
         DS_GL: nxt.gl = res;
         DS_BY: nxt.by = res;
         DS_FR: nxt.fr = res;
         DS_KL: nxt.kl = res;
         DS_DL: nxt.dl = res;
         DS_DH: nxt.dh = res;
         DS_OP: nxt.op = res;
         DS_GP: nxt.gp = res;
         DS_UR: nxt.ur = res;
         DS_DW: begin
            nxt.dw = res;
            dw_wr  = 1'b1;
         end
         DS_DR: nxt.dr = res;
         // mask update: clear the result bits, or set them when next_low bit 2 is one
         DS_FT: nxt.ft = item.next_low[2] ? (cur.ft | res) : (cur.ft & ~res);
         DS_FC: nxt.fc = item.next_low[2] ? (cur.fc | res) : (cur.fc & ~res);
         DS_IG: nxt.ig = res;
         DS_SP: nxt.sp = res;
         DS_IE: nxt.ie = {3'b000, res[4:0]};
         default: ;
      endcase

      st = cur.status;
      if (item.alu_function == AF_ADDS || item.alu_function == AF_ADD1S
          || item.alu_function == AF_ADDST3) begin
         st[4] = carry;
      end
      unique case (item.status_op)
         SO_NOP:            ;
         SO_CLR0, SO_CLR0B: st[7] = 1'b0;
         SO_CLR1:           st[6] = 1'b0;
         SO_SET1:           st[6] = 1'b1;
         SO_CLR2:           st[5] = 1'b0;
         SO_CLR2NZ:         if (alu != 8'h00) st[5] = 1'b0;
         SO_SET3:           st[4] = 1'b1;
         SO_CLR3:           st[4] = 1'b0;
         SO_SET4:           st[3] = 1'b1;
         SO_CLR5:           st[2] = 1'b0;
         SO_SET5:           st[2] = 1'b1;
         SO_CLR6:           st[1] = 1'b0;
         SO_SET6:           st[1] = 1'b1;
         SO_CLR7:           st[0] = 1'b0;
         SO_SET7:           st[0] = 1'b1;
         default:           ;
      endcase
      nxt.status = st;
   end

   always_comb begin
      rsp.next_address  = nx;
      rsp.alu_result    = res;
      rsp.a_bus         = a;
      rsp.carry_flag    = carry;
      rsp.nonzero_flag  = (alu != 8'h00);
      rsp.status_reg    = nxt.status;
      rsp.op_reg_out    = nxt.op;
      rsp.data_word_out = nxt.dw;
      rsp.tag_gate_out  = nxt.ig;
      rsp.ft_out        = nxt.ft;
      rsp.fc_out        = nxt.fc;
      rsp.data_written  = dw_wr;
   end

endmodule
